### rtl/core/swcd_pkg.sv
// -----------------------------------------------------------------------------
// swcd_pkg
// Shared types and constants for the sliding-window critical detector.
// -----------------------------------------------------------------------------
package swcd_pkg;

	localparam int WINDOW_DEF = 5;
	localparam int DATA_W     = 16;
	localparam int COUNT_W    = 16;
	localparam int MHC_W      = 3;
	localparam int PADDR_W    = 4;
	localparam int PDATA_W    = 32;

	localparam logic signed [DATA_W-1:0] CEILING_RST    = 16'sd150;
	localparam logic signed [DATA_W-1:0] HIGH_LEVEL_RST = 16'sd70;
	localparam logic        [MHC_W-1:0]  MIN_HIGH_RST   = 3'd3;
	localparam logic signed [DATA_W-1:0] MIN_AVG_RST    = 16'sd90;

	typedef enum logic [1:0] {
		REG_CEILING    = 2'd0,
		REG_HIGH_LEVEL = 2'd1,
		REG_MIN_HIGH   = 2'd2,
		REG_MIN_AVG    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] ceiling;
		logic signed [DATA_W-1:0] high_level;
		logic        [MHC_W-1:0]  min_high_count;
		logic signed [DATA_W-1:0] min_average;
	} cfg_t;

	typedef struct packed {
		logic                     start_of_set;
		logic signed [DATA_W-1:0] reading;
	} sample_t;

	typedef struct packed {
		logic               window_full;
		logic               critical;
		logic [COUNT_W-1:0] critical_count;
	} result_t;

	// control that rides with the window register
	typedef struct packed {
		logic start;
		logic full;
	} stage_ctl_t;

endpackage

### rtl/core/swcd_regs.sv
// -----------------------------------------------------------------------------
// swcd_regs
// APB register file for the detector thresholds.
// -----------------------------------------------------------------------------
module swcd_regs
	import swcd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ceiling        <= CEILING_RST;
			cfg_q.high_level     <= HIGH_LEVEL_RST;
			cfg_q.min_high_count <= MIN_HIGH_RST;
			cfg_q.min_average    <= MIN_AVG_RST;
		end else if (wr_en) begin
			case (idx)
				REG_CEILING:    cfg_q.ceiling        <= pwdata[DATA_W-1:0];
				REG_HIGH_LEVEL: cfg_q.high_level     <= pwdata[DATA_W-1:0];
				REG_MIN_HIGH:   cfg_q.min_high_count <= pwdata[MHC_W-1:0];
				REG_MIN_AVG:    cfg_q.min_average    <= pwdata[DATA_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_CEILING:    prdata = {{(PDATA_W-DATA_W){1'b0}}, cfg_q.ceiling};
			REG_HIGH_LEVEL: prdata = {{(PDATA_W-DATA_W){1'b0}}, cfg_q.high_level};
			REG_MIN_HIGH:   prdata = {{(PDATA_W-MHC_W){1'b0}}, cfg_q.min_high_count};
			REG_MIN_AVG:    prdata = {{(PDATA_W-DATA_W){1'b0}}, cfg_q.min_average};
			default:        prdata = '0;
		endcase
	end

endmodule

### rtl/core/swcd_hist.sv
// -----------------------------------------------------------------------------
// swcd_hist
// Reading history shift line, fill tracking and the window register.
// -----------------------------------------------------------------------------
module swcd_hist
	import swcd_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  sample_t                  sample,
	output logic signed [DATA_W-1:0] window_s1 [WINDOW],
	output stage_ctl_t               ctl_s1
);

	localparam int FILL_W = (WINDOW > 2) ? $clog2(WINDOW) : 1;
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW - 1);

	logic signed [DATA_W-1:0] hist_q [WINDOW-1];
	logic        [FILL_W-1:0] fill_q;
	logic        [FILL_W-1:0] fill_eff;
	logic                     full;

	// start of set drops the fill; stale entries are never judged
	assign fill_eff = sample.start_of_set ? '0 : fill_q;
	assign full     = (fill_eff == FILL_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= full ? fill_eff : fill_eff + 1'b1;
		end
	end

	// newest reading enters at the top, oldest sits at index 0
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < WINDOW - 2; i++) begin
				hist_q[i] <= hist_q[i+1];
			end
			hist_q[WINDOW-2] <= sample.reading;
			for (int i = 0; i < WINDOW - 1; i++) begin
				window_s1[i] <= hist_q[i];
			end
			window_s1[WINDOW-1] <= sample.reading;
			ctl_s1.start        <= sample.start_of_set;
			ctl_s1.full         <= full;
		end
	end

endmodule

### rtl/core/swcd_judge.sv
// -----------------------------------------------------------------------------
// swcd_judge
// Parallel window test: ceiling, high count and truncated average.
// -----------------------------------------------------------------------------
module swcd_judge
	import swcd_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic signed [DATA_W-1:0] window [WINDOW],
	input  cfg_t                     cfg,
	output logic                     critical
);

	localparam int SUM_W = DATA_W + $clog2(WINDOW);
	localparam int THR_W = SUM_W + 2;
	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int CMP_W = (CNT_W > MHC_W) ? CNT_W : MHC_W;
	localparam logic signed [THR_W-1:0] WIN_S = THR_W'(WINDOW);

	logic                    over;
	logic [CNT_W-1:0]        highs;
	logic signed [SUM_W-1:0] sum;
	logic signed [THR_W-1:0] avg_x;
	logic signed [THR_W-1:0] thr;
	logic                    avg_pos;
	logic                    high_ok;
	logic                    avg_ok;

	always_comb begin
		over  = 1'b0;
		highs = '0;
		sum   = '0;
		for (int i = 0; i < WINDOW; i++) begin
			if (window[i] > cfg.ceiling) begin
				over = 1'b1;
			end
			if (window[i] >= cfg.high_level) begin
				highs = highs + 1'b1;
			end
			sum = sum + SUM_W'(window[i]);
		end
	end

	// trunc(sum/W) >= m  <=>  sum >= m*W for m > 0, sum > (m-1)*W otherwise
	assign avg_x   = THR_W'(cfg.min_average);
	assign avg_pos = (cfg.min_average > 0);
	assign thr     = avg_pos ? avg_x * WIN_S : (avg_x - THR_W'(1)) * WIN_S + THR_W'(1);

	assign high_ok  = CMP_W'(highs) >= CMP_W'(cfg.min_high_count);
	assign avg_ok   = THR_W'(sum) >= thr;
	assign critical = !over && high_ok && avg_ok;

endmodule

### rtl/core/sliding_window_critical_detector.sv
// -----------------------------------------------------------------------------
// sliding_window_critical_detector
// Sliding-window threshold detector with a saturating critical-window count.
// -----------------------------------------------------------------------------
// Takes one reading per cycle while the sample side is not stalled and returns
// one result word per reading. The reading passes through the window register
// and then the result register before its word is presented. A shift line
// holds the last WINDOW-1 readings; on accept the full window is copied into a
// window register, and the ceiling test, high-level count, window sum and
// average threshold compare all sit between that register and the result
// register. Back-pressure on the result side reaches the sample side only when
// both stages are occupied. Thresholds are APB registers and must only be
// written while the block is empty.
module sliding_window_critical_detector
	import swcd_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  sample_t            sample,
	output logic               result_valid,
	input  logic               result_stall,
	output result_t            result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t                     cfg;
	logic signed [DATA_W-1:0] window_s1 [WINDOW];
	stage_ctl_t               ctl_s1;
	logic                     valid_s1;
	logic                     valid_s2;
	result_t                  result_s2;
	logic [COUNT_W-1:0]       tally_q;
	logic [COUNT_W-1:0]       tally_base;
	logic [COUNT_W-1:0]       tally_next;
	logic                     judged;
	logic                     crit;
	logic                     adv_s2;
	logic                     adv_s1;
	logic                     accept;

	assign adv_s2       = !valid_s2 || !result_stall;
	assign adv_s1       = !valid_s1 || adv_s2;
	assign sample_stall = !adv_s1;
	assign accept       = sample_valid && adv_s1;

	swcd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	swcd_hist #(.WINDOW(WINDOW)) u_hist (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.sample    (sample),
		.window_s1 (window_s1),
		.ctl_s1    (ctl_s1)
	);

	swcd_judge #(.WINDOW(WINDOW)) u_judge (
		.window   (window_s1),
		.cfg      (cfg),
		.critical (judged)
	);

	assign crit       = ctl_s1.full && judged;
	assign tally_base = ctl_s1.start ? '0 : tally_q;
	assign tally_next = (crit && (tally_base != '1)) ? tally_base + 1'b1 : tally_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			tally_q  <= '0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= sample_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					tally_q <= tally_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			result_s2.window_full    <= ctl_s1.full;
			result_s2.critical       <= crit;
			result_s2.critical_count <= tally_next;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

### rtl/core/swcd_checker.sv
// -----------------------------------------------------------------------------
// swcd_checker
// Port-level checks for the sliding-window critical detector.
// -----------------------------------------------------------------------------
module swcd_checker
	import swcd_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    sample_valid,
	input logic    sample_stall,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result,
	input logic    pready
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	a_crit_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.critical |-> result.window_full)
		else $error("critical flagged on a partial window");

	a_crit_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.critical |-> result.critical_count != '0)
		else $error("critical window left count at zero");

	// input side only backs up when the output side is stalled and full
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> result_valid && result_stall && pready)
		else $error("sample stall without result back-pressure");

endmodule

bind sliding_window_critical_detector swcd_checker u_swcd_checker (.*);

### tb/sv/testbench.sv
// -----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sliding-window critical detector.
// -----------------------------------------------------------------------------
// Sample words come from a queue and go to the block through a clocked
// driver. A clocked monitor scores each result word against a local window
// predictor. Thresholds are written over APB only while the block is empty.
// The run covers the reset thresholds, the extreme settings, random settings
// with random stalls on both sides, and a closing stream in which every full
// window is critical.
module testbench;
	import swcd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN          = WINDOW_DEF;
	localparam int HIST         = WIN - 1;
	localparam int TALLY_MAX    = 65535;
	localparam int HOLD_CYCLES  = 60;
	localparam int RAND_PHASES  = 7;
	localparam int PHASE_WORDS  = 140;
	localparam int CRIT_WORDS   = 20;
	localparam int MAX_SHOWN    = 10;

	logic               clk;
	logic               arst_n       = 1'b0;
	logic               sample_valid = 1'b0;
	logic               sample_stall;
	sample_t            sample       = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	result_t            result;
	logic               psel         = 1'b0;
	logic               penable      = 1'b0;
	logic               pwrite       = 1'b0;
	logic [PADDR_W-1:0] paddr        = '0;
	logic [PDATA_W-1:0] pwdata       = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	sliding_window_critical_detector i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// window predictor state and threshold copies
	logic signed [DATA_W-1:0] hist_words [HIST];
	int                       fill_cnt   = 0;
	int                       crit_tally = 0;
	int                       ceil_c     = CEILING_RST;
	int                       high_c     = HIGH_LEVEL_RST;
	int                       mhc_c      = MIN_HIGH_RST;
	int                       avg_c      = MIN_AVG_RST;

	sample_t pending_words [$];
	result_t expected_results [$];

	int      mismatches  = 0;
	logic    tx_accepted = 1'b0;
	int      tx_gap      = 0;
	int      rx_gap      = 0;
	int      tx_idle_pct = 0;
	int      rx_idle_pct = 0;
	int      hold_asks   = 0;
	int      hold_seen   = 0;
	int      hold_left   = 0;
	result_t want;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic result_t judge_reading(sample_t s);
		result_t r;
		int      sum;
		int      highs;
		int      v;
		bit      over;
		r = '0;
		if (s.start_of_set) begin
			foreach (hist_words[i]) hist_words[i] = '0;
			fill_cnt   = 0;
			crit_tally = 0;
		end
		if (fill_cnt >= HIST) begin
			v     = int'($signed(s.reading));
			sum   = v;
			highs = (v >= high_c);
			over  = (v > ceil_c);
			for (int i = 0; i < HIST; i++) begin
				v     = int'(hist_words[i]);
				sum   += v;
				highs += (v >= high_c);
				over  |= (v > ceil_c);
			end
			r.window_full = 1'b1;
			// int division truncates toward zero, as the average must
			if (!over && highs >= mhc_c && sum / WIN >= avg_c) begin
				r.critical = 1'b1;
				if (crit_tally < TALLY_MAX)
					crit_tally++;
			end
			for (int i = 0; i < HIST - 1; i++)
				hist_words[i] = hist_words[i + 1];
			hist_words[HIST - 1] = s.reading;
		end else begin
			hist_words[fill_cnt] = s.reading;
			fill_cnt++;
		end
		r.critical_count = crit_tally[COUNT_W-1:0];
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] rand_reading();
		int v;
		case ($urandom_range(9))
			0: v = int'($urandom);
			1: begin
				case ($urandom_range(3))
					0: v = -32768;
					1: v = 32767;
					2: v = 0;
					default: v = -1;
				endcase
			end
			default: begin
				case ($urandom_range(2))
					0: v = ceil_c;
					1: v = high_c;
					default: v = avg_c;
				endcase
				v = v + int'($urandom_range(40)) - 20;
				if (v > 32767)
					v = 32767;
				if (v < -32768)
					v = -32768;
			end
		endcase
		return v[DATA_W-1:0];
	endfunction

	task automatic log_mismatch(string what, result_t e, result_t a);
		mismatches++;
		if (mismatches <= MAX_SHOWN)
			$display("%0t: %s: expected full=%0b crit=%0b count=%0d, got full=%0b crit=%0b count=%0d",
				$realtime, what, e.window_full, e.critical, e.critical_count,
				a.window_full, a.critical, a.critical_count);
	endtask

	// accept side and scoreboard
	always @(posedge clk) begin
		if (arst_n) begin
			tx_accepted <= sample_valid && !sample_stall;
			if (sample_valid && !sample_stall) begin
				expected_results.push_back(judge_reading(sample));
				void'(pending_words.pop_front());
			end
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					log_mismatch("unexpected result word", '0, result);
				end else begin
					want = expected_results.pop_front();
					if (result.window_full !== want.window_full ||
							result.critical !== want.critical ||
							result.critical_count !== want.critical_count)
						log_mismatch("result mismatch", want, result);
				end
			end
		end
	end

	// sample driver; holds the word until it is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else if (sample_valid && !tx_accepted) begin
		end else if (tx_gap > 0) begin
			sample_valid <= 1'b0;
			tx_gap       <= tx_gap - 1;
		end else if (pending_words.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
			sample_valid <= 1'b1;
			sample       <= pending_words[0];
		end else if (pending_words.size() > 0) begin
			sample_valid <= 1'b0;
			tx_gap       <= $urandom_range(12);
		end else begin
			sample_valid <= 1'b0;
		end
	end

	// long receiver hold-off, counted here
	always @(negedge clk) begin
		if (hold_seen != hold_asks) begin
			hold_seen <= hold_asks;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else if (hold_left > 0) begin
			result_stall <= 1'b1;
		end else if (rx_gap > 0) begin
			result_stall <= 1'b1;
			rx_gap       <= rx_gap - 1;
		end else if ($urandom_range(99) < rx_idle_pct) begin
			result_stall <= 1'b1;
			rx_gap       <= $urandom_range(12);
		end else begin
			result_stall <= 1'b0;
		end
	end

	task automatic write_reg(reg_idx_t idx, int val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_CEILING:    ceil_c = int'($signed(val[15:0]));
			REG_HIGH_LEVEL: high_c = int'($signed(val[15:0]));
			REG_MIN_HIGH:   mhc_c  = val & 7;
			REG_MIN_AVG:    avg_c  = int'($signed(val[15:0]));
			default: ;
		endcase
	endtask

	task automatic set_thresholds(int ceil_v, int high_v, int mhc_v, int avg_v);
		write_reg(REG_CEILING, ceil_v);
		write_reg(REG_HIGH_LEVEL, high_v);
		write_reg(REG_MIN_HIGH, mhc_v);
		write_reg(REG_MIN_AVG, avg_v);
		@(posedge clk);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_words.size() != 0 || expected_results.size() != 0);
	endtask

	task automatic push_word(bit sos, int rd);
		sample_t w;
		w.start_of_set = sos;
		w.reading      = rd[DATA_W-1:0];
		pending_words.push_back(w);
	endtask

	task automatic push_random(int n, int start_pct);
		for (int i = 0; i < n; i++)
			push_word($urandom_range(99) < start_pct, int'($signed(rand_reading())));
	endtask

	initial begin
		int wait_cnt;
		foreach (hist_words[i]) hist_words[i] = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset thresholds: first full window, ceiling edge, average edge, extremes
		push_word(1, 100);
		repeat (4) push_word(0, 100);
		push_word(0, 150);
		push_word(0, 151);
		push_word(0, -32768);
		push_word(0, 32767);
		push_word(1, 90);
		repeat (3) push_word(0, 90);
		push_word(0, 89);
		push_word(0, 91);

		// negative average must truncate toward zero
		wait_drained();
		set_thresholds(32767, -32768, 0, -1);
		push_word(1, -1);
		repeat (4) push_word(0, -2);
		push_word(0, -3);

		// opposite extremes: nothing can be critical
		wait_drained();
		set_thresholds(-32768, 32767, 7, 32767);
		push_random(30, 5);

		for (int p = 0; p < RAND_PHASES; p++) begin
			wait_drained();
			set_thresholds(
				($urandom_range(3) == 0) ? int'($urandom) : 50 + int'($urandom_range(250)),
				($urandom_range(3) == 0) ? int'($urandom) : int'($urandom_range(200)) - 50,
				$urandom_range(7),
				($urandom_range(3) == 0) ? int'($urandom) : int'($urandom_range(250)) - 80);
			case ($urandom_range(2))
				0: tx_idle_pct = 0;
				1: tx_idle_pct = 15;
				default: tx_idle_pct = 40;
			endcase
			rx_idle_pct = $urandom_range(40);
			if (p == 2) begin
				// fill the pipe against a held-off receiver
				tx_idle_pct = 0;
				hold_asks++;
			end
			if (p == RAND_PHASES - 1) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			push_random(PHASE_WORDS, 2);
		end

		// every full window critical, count climbs on each full window
		wait_drained();
		set_thresholds(32767, -32768, 0, -32768);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		push_word(1, int'($signed(rand_reading())));
		push_random(CRIT_WORDS - 1, 0);

		wait_drained();
		wait_cnt = 0;
		while (wait_cnt < 20) begin
			@(negedge clk);
			wait_cnt++;
		end
		mismatches += expected_results.size();
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
